// ===== hdl/tdpt_pkg.sv =====
// ---------------------------------------------------------------------------
// tdpt_pkg: shared types and constants for the trial division prime test
// Holds the default data width, the first trial divisor and the sequencer state encoding.
// ---------------------------------------------------------------------------
package tdpt_pkg;

    // Default width of the candidate and of the tested value
    localparam int DEF_WIDTH = 32;

    // First odd trial divisor
    localparam int FIRST_DIVISOR = 3;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_FIN
    } t_state;

endpackage

// ===== hdl/tdpt_serial_div.sv =====
// ---------------------------------------------------------------------------
// tdpt_serial_div: bit-serial restoring divider
// Produces one quotient bit per cycle; quotient and remainder hold after done.
// ---------------------------------------------------------------------------
module tdpt_serial_div #(
    parameter int WIDTH = tdpt_pkg::DEF_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quotient,
    output logic [WIDTH-1:0] o_remainder
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] r_num;
    logic [WIDTH-1:0] r_div;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_quo;
    logic [CW-1:0]    r_cnt;
    logic             r_done;

    logic [WIDTH:0]   w_trial;
    logic [WIDTH:0]   w_diff;
    logic             w_ge;
    logic [WIDTH-1:0] n_rem;

    // Bring down the next dividend bit and try one subtract
    always_comb begin
        w_trial = {r_rem, r_num[WIDTH-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_ge    = ~w_diff[WIDTH];
        n_rem   = w_ge ? w_diff[WIDTH-1:0] : w_trial[WIDTH-1:0];
    end

    // Control: step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CW'(WIDTH);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == CW'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    // Datapath: shift dividend out, shift quotient bits in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            r_num <= {r_num[WIDTH-2:0], 1'b0};
            r_rem <= n_rem;
            r_quo <= {r_quo[WIDTH-2:0], w_ge};
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ===== hdl/trial_division_prime_test.sv =====
// ---------------------------------------------------------------------------
// trial_division_prime_test: primality test by trial division
// Accepts one candidate per beat and returns it with a prime flag.
// ---------------------------------------------------------------------------
// One candidate is tested at a time. Zero, one and even numbers go straight
// to the finish state (two is prime, the rest are not). An odd candidate n is
// divided by 3, 5, 7, ... until the divisor exceeds the quotient or a
// remainder is zero; each trial goes through the bit-serial divider. The
// result sits in an output register, so the next candidate is taken while
// the previous result still waits for the downstream side.
// ---------------------------------------------------------------------------
module trial_division_prime_test #(
    parameter int WIDTH = tdpt_pkg::DEF_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [WIDTH-1:0] i_candidate,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [WIDTH-1:0] o_tested_value,
    output logic             o_is_prime
);

    import tdpt_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic [WIDTH-1:0] r_n;
    logic [WIDTH-1:0] r_d;
    logic             r_prime;
    logic             r_ovalid;
    logic [WIDTH-1:0] r_oval;
    logic             r_oprime;

    logic             w_accept;
    logic             w_trivial;
    logic             w_div_start;
    logic             w_div_done;
    logic [WIDTH-1:0] w_quo;
    logic [WIDTH-1:0] w_rem;
    logic             w_out_free;
    logic             w_fin_load;
    logic             w_stop_prime;
    logic             w_stop_comp;

    // Shared remainder unit
    tdpt_serial_div #(
        .WIDTH (WIDTH)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (r_n),
        .i_divisor   (r_d),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    // Decode the candidate and the trial outcome
    always_comb begin
        w_accept     = i_valid && !o_stall;
        w_trivial    = (i_candidate < WIDTH'(3)) || !i_candidate[0];
        w_stop_prime = w_quo < r_d;
        w_stop_comp  = (w_rem == '0);
        w_out_free   = !r_ovalid || !i_stall;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_trivial ? S_FIN : S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = (w_stop_prime || w_stop_comp) ? S_FIN : S_LOAD;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        o_stall     = 1'b1;
        w_div_start = 1'b0;
        w_fin_load  = 1'b0;
        unique case (r_state)
            S_IDLE:  o_stall     = 1'b0;
            S_LOAD:  w_div_start = 1'b1;
            S_DIV:   ;
            S_FIN:   w_fin_load  = w_out_free;
            default: ;
        endcase
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the candidate, advance the divisor, settle the verdict
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_n     <= i_candidate;
            r_d     <= WIDTH'(FIRST_DIVISOR);
            r_prime <= (i_candidate == WIDTH'(2));
        end else if (r_state == S_DIV && w_div_done) begin
            if (w_stop_prime) begin
                r_prime <= 1'b1;
            end else if (w_stop_comp) begin
                r_prime <= 1'b0;
            end else begin
                r_d <= r_d + WIDTH'(2);
            end
        end
    end

    // Output register: load a finished result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_fin_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_load) begin
            r_oval   <= r_n;
            r_oprime <= r_prime;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_tested_value = r_oval;
    assign o_is_prime     = r_oprime;

    // A division is started only from the load state and runs next
    a_start_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |=> (r_state == S_DIV))
        else $error("divider start not followed by division state");

    // Trial divisors stay odd while dividing
    a_divisor_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> r_d[0])
        else $error("even trial divisor");

    // A prime verdict is only given to two or an odd number above one
    a_prime_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_prime) |->
            ((o_tested_value == WIDTH'(2)) ||
             (o_tested_value[0] && (o_tested_value != WIDTH'(1)))))
        else $error("prime flag on impossible value");

    // A result is never overwritten while it waits
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_stall) |-> !w_fin_load)
        else $error("pending result overwritten");

endmodule

// ===== tb/trial_division_prime_test_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// trial_division_prime_test_tb: self-checking bench for the prime tester
// Feeds candidates through the valid/stall input channel and checks every
// result beat against a trial-division predictor. Directed boundary values
// run first, then random candidates under several idle and stall mixes.
// ---------------------------------------------------------------------------
module trial_division_prime_test_tb;

    localparam int W           = tdpt_pkg::DEF_WIDTH;
    localparam int QUIET_LIMIT = 400000;

    typedef struct packed {
        logic [W-1:0] value;
        logic         prime;
    } t_prime_verdict;

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         i_valid = 1'b0;
    logic         o_stall;
    logic [W-1:0] i_candidate = '0;
    logic         o_valid;
    logic         i_stall = 1'b0;
    logic [W-1:0] o_tested_value;
    logic         o_is_prime;

    logic [W-1:0]   cand_pending [$];
    t_prime_verdict verdict_expected [$];
    logic           cand_taken;
    int             quiet_cycles;
    int             error_count = 0;
    int             tx_idle_pct = 0;
    int             rx_stall_pct = 0;

    // Boundaries, small squares of primes, near-power-of-two primes, all-ones
    logic [W-1:0] directed_vals [$] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd15, 32'd25, 32'd49,
        32'd289, 32'd65521, 32'd65535, 32'd65536, 32'd1048573, 32'd16777213,
        32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hAAAA_AAAB, 32'h5555_5555
    };

    trial_division_prime_test #(
        .WIDTH (W)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_candidate    (i_candidate),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_tested_value (o_tested_value),
        .o_is_prime     (o_is_prime)
    );

    always #4 i_clk = ~i_clk;

    // Odd divisors only, stop once d exceeds n / d
    function automatic logic prime_by_trial(logic [W-1:0] cand);
        longint unsigned n;
        longint unsigned d;
        n = 64'(cand);
        if (n < 2) return 1'b0;
        if (n[0] == 1'b0) return n == 2;
        for (d = 3; d <= n / d; d += 2) begin
            if (n % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Mostly small numbers; large ones are even or carry a small odd factor,
    // which keeps the divider loop short
    function automatic logic [W-1:0] random_candidate();
        int           sel;
        int           k;
        int           p;
        logic [W-1:0] r;
        int           small_primes [10] = '{3, 5, 7, 11, 13, 17, 19, 23, 29, 31};
        sel = $urandom_range(0, 9);
        r   = W'($urandom);
        if (sel <= 5) begin
            k = $urandom_range(1, 16);
            r = r & ((W'(1) << k) - W'(1));
        end else if (sel == 6) begin
            r[0] = 1'b0;
        end else begin
            p = small_primes[$urandom_range(0, 9)];
            r = r - (r % W'(p));
        end
        return r;
    endfunction

    // Hold until every queued candidate is sent and every result is back
    task automatic drain_all();
        while (cand_pending.size() != 0 || i_valid || verdict_expected.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_random_phase(int tx_pct, int rx_pct, int count);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (count) cand_pending.push_back(random_candidate());
        drain_all();
    endtask

    // Drive candidate beats and downstream stall on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 99) < rx_stall_pct);
            if (!i_valid || cand_taken) begin
                if (cand_pending.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    i_valid     <= 1'b1;
                    i_candidate <= cand_pending.pop_front();
                end else begin
                    i_valid     <= 1'b0;
                    i_candidate <= W'($urandom);
                end
            end
        end
    end

    // Sample both channels on the rising edge, check results, run watchdog
    always @(posedge i_clk) begin : monitor
        t_prime_verdict want;
        logic           in_beat;
        logic           out_beat;
        in_beat  = i_valid && !o_stall;
        out_beat = o_valid && !i_stall;
        if (!i_rst_n) begin
            cand_taken   <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            cand_taken <= in_beat;
            if (out_beat) begin
                if (verdict_expected.size() == 0) begin
                    $error("result beat with nothing expected: tested_value %0d is_prime %0d",
                           o_tested_value, o_is_prime);
                    $display("== FAIL ==");
                    $finish;
                end else begin
                    want = verdict_expected.pop_front();
                    if (o_tested_value !== want.value) begin
                        $error("tested_value: expected %0d, got %0d", want.value,
                               o_tested_value);
                        error_count++;
                    end
                    if (o_is_prime !== want.prime) begin
                        $error("is_prime: expected %0d, got %0d (candidate %0d)",
                               want.prime, o_is_prime, want.value);
                        error_count++;
                    end
                end
            end
            if (in_beat)
                verdict_expected.push_back('{value: i_candidate,
                                             prime: prime_by_trial(i_candidate)});
            if (in_beat || out_beat) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
                $display("== FAIL ==");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Reset, directed values, then random phases with different idle and stall mixes
    initial begin
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_vals[i]) cand_pending.push_back(directed_vals[i]);
        drain_all();

        run_random_phase(0, 0, 20);
        run_random_phase(78, 0, 20);
        run_random_phase(0, 78, 20);
        run_random_phase(38, 38, 20);

        repeat (50) @(posedge i_clk);
        if (error_count == 0 && verdict_expected.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
